[rtl/core/ctp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared constants and command/status types of the task picker.
// ----------------------------------------------------------------------------
package ctp_pkg;
	localparam int MAX_TASKS_DEF  = 16;
	localparam int MAX_ROUNDS_DEF = 4;
	localparam logic [15:0] MIN_WAIT   = 16'd5;
	localparam logic [15:0] FIRST_WAIT = 16'd1;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_STOP   = 2'd1;
	localparam logic [1:0] CMD_RESUME = 2'd2;
	localparam logic [1:0] CMD_YIELD  = 2'd3;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_NONE    = 2'd3;

	typedef struct packed {
		logic start;    // latch the item, begin decode
		logic pre;      // decode and apply add/stop/resume; yield: record the yielding slot
		logic visit;    // advance the cursor and read the next slot's tables (yield)
		logic judge;    // yield: act on the registered read
		logic finish;   // load the result register
	} ctp_cmd_t;

	typedef struct packed {
		logic       simple;   // command finished at decode
		logic       pick;     // judged slot is eligible
		logic       exhaust;  // walk limit reached
	} ctp_stat_t;
endpackage
`default_nettype wire

[rtl/core/ctp_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_datapath
// Slot tables, ring cursor and command evaluation.
// ----------------------------------------------------------------------------
module ctp_datapath import ctp_pkg::*; #(
	parameter int MAX_TASKS  = MAX_TASKS_DEF,
	parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ctp_cmd_t    cmd,
	output ctp_stat_t        stat,
	input  wire logic [1:0]  command,
	input  wire logic [3:0]  task_slot,
	input  wire logic [31:0] now_us,
	input  wire logic [15:0] wait_us,
	input  wire logic        from_isr,
	output logic [1:0]       status,
	output logic [3:0]       running_slot,
	output logic [3:0]       new_slot
);
	localparam int IW = $clog2(MAX_TASKS);
	localparam int XW = (IW > 4) ? IW : 4;
	localparam int LIMIT = MAX_ROUNDS * MAX_TASKS;
	localparam int SW = $clog2(LIMIT + 1);

	logic [MAX_TASKS-1:0] active_q;
	logic [15:0] wait_mem [MAX_TASKS];
	logic [31:0] ytime_mem [MAX_TASKS];
	logic [31:0] stime_mem [MAX_TASKS];
	logic [31:0] mrun_mem [MAX_TASKS];

	logic [IW-1:0] count_q, run_q, cur_q;
	logic [1:0] cmd_q;
	logic [3:0] slot_q;
	logic [31:0] now_q;
	logic [15:0] wt_q;
	logic intr_q;
	logic [SW-1:0] steps_q, limit_q;
	logic [1:0] st_q;
	logic [IW-1:0] add_q;

	logic [15:0] rw_q;
	logic [31:0] ry_q, rs_q, rm_q;
	logic ract_q;

	logic [IW-1:0] nxt;
	logic [XW-1:0] slot_x, count_x;
	logic full, bad_slot, skip_y, wait_block;
	logic [31:0] dt;

	assign nxt = (cur_q >= count_q) ? '0 : cur_q + 1'b1;
	assign full = ({1'b0, count_q} + 1'b1) >= (IW+1)'(MAX_TASKS);
	assign slot_x = XW'(slot_q);
	assign count_x = XW'(count_q);
	assign bad_slot = (slot_q == 4'd0) || (slot_x > count_x)
		|| (32'(slot_q) >= 32'(MAX_TASKS));
	assign skip_y = (count_q == '0) || (wt_q != 16'd0 && wt_q < MIN_WAIT) || intr_q;
	assign wait_block = (rw_q != 16'd0) && ((now_q - ry_q) < {16'd0, rw_q});
	assign dt = now_q - rs_q;

	assign stat.simple = (cmd_q != CMD_YIELD) || skip_y;
	assign stat.pick = ract_q && !wait_block && !(cur_q != '0 && rm_q > {16'd0, wt_q});
	assign stat.exhaust = (steps_q == limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= {{(MAX_TASKS-1){1'b0}}, 1'b1};
			count_q <= '0;
			run_q <= '0;
			for (int i = 0; i < MAX_TASKS; i++) begin
				wait_mem[i] <= '0;
				ytime_mem[i] <= '0;
				stime_mem[i] <= '0;
				mrun_mem[i] <= '0;
			end
		end else begin
			if (cmd.pre) begin
				unique case (cmd_q)
					CMD_ADD: if (!full) begin
						count_q <= count_q + 1'b1;
						active_q[count_q + 1'b1] <= 1'b1;
						wait_mem[count_q + 1'b1] <= FIRST_WAIT;
						mrun_mem[count_q + 1'b1] <= '0;
						ytime_mem[count_q + 1'b1] <= now_q;
						stime_mem[count_q + 1'b1] <= now_q;
					end
					CMD_STOP: if (!bad_slot) active_q[slot_x[IW-1:0]] <= 1'b0;
					CMD_RESUME: if (!bad_slot) active_q[slot_x[IW-1:0]] <= 1'b1;
					default: if (!skip_y) begin
						ytime_mem[run_q] <= now_q;
						wait_mem[run_q] <= wt_q;
						if (dt > rm_q) mrun_mem[run_q] <= dt;
					end
				endcase
			end
			if (cmd.judge) begin
				if (stat.pick) begin
					run_q <= cur_q;
					wait_mem[cur_q] <= 16'd0;
					stime_mem[cur_q] <= now_q;
				end else if (ract_q && !wait_block) begin
					mrun_mem[cur_q] <= rm_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cmd_q <= command;
			slot_q <= task_slot;
			now_q <= now_us;
			wt_q <= wait_us;
			intr_q <= from_isr;
			st_q <= ST_DONE;
			add_q <= '0;
			rs_q <= stime_mem[run_q];
			rm_q <= mrun_mem[run_q];
		end
		if (cmd.pre) begin
			cur_q <= run_q;
			steps_q <= '0;
			limit_q <= SW'(MAX_ROUNDS * (32'(count_q) + 1));
			unique case (cmd_q)
				CMD_ADD: if (full) st_q <= ST_FULL; else add_q <= count_q + 1'b1;
				CMD_STOP, CMD_RESUME: if (bad_slot) st_q <= ST_IGNORED;
				default: if (skip_y) st_q <= ST_IGNORED;
			endcase
		end
		if (cmd.visit) begin
			cur_q <= nxt;
			steps_q <= steps_q + 1'b1;
			ract_q <= active_q[nxt];
			rw_q <= wait_mem[nxt];
			ry_q <= ytime_mem[nxt];
			rm_q <= mrun_mem[nxt];
		end
		if (cmd.judge) begin
			if (!stat.pick && stat.exhaust) st_q <= ST_NONE;
		end
		if (cmd.finish) begin
			status <= st_q;
			running_slot <= 4'(run_q);
			new_slot <= 4'(add_q);
		end
	end
endmodule
`default_nettype wire

[rtl/core/ctp_control.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_control
// Sequencer for decode, ring walk and result hand-off.
// ----------------------------------------------------------------------------
module ctp_control import ctp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  wire logic       out_stall,
	input  wire ctp_stat_t  stat,
	output ctp_cmd_t        cmd
);
	localparam logic [2:0] S_IDLE = 3'd0, S_PRE = 3'd1, S_VISIT = 3'd2,
		S_JUDGE = 3'd3, S_FIN = 3'd4;
	logic [2:0] state_q;
	logic done;

	assign in_stall = (state_q != S_IDLE);
	assign cmd.start = in_valid && !in_stall;
	assign cmd.pre = state_q == S_PRE;
	assign cmd.visit = state_q == S_VISIT;
	assign cmd.judge = state_q == S_JUDGE;
	assign cmd.finish = state_q == S_FIN && !(out_valid && out_stall);
	assign done = cmd.finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (done) out_valid <= 1'b1;
			unique case (state_q)
				S_IDLE: if (cmd.start) state_q <= S_PRE;
				S_PRE: state_q <= stat.simple ? S_FIN : S_VISIT;
				S_VISIT: state_q <= S_JUDGE;
				S_JUDGE: state_q <= (stat.pick || stat.exhaust) ? S_FIN : S_VISIT;
				S_FIN: if (done) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/core/cooperative_task_picker_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cooperative_task_picker_unit
// Round-robin cooperative task picker over a table of task slots.
//
// One beat on the input channel (command, task_slot, now_us, wait_us,
// from_isr) gives one beat on the output channel (status, running_slot,
// new_slot). Add, stop, resume and a skipped yield go from decode straight
// to the result load. A taken yield walks the ring one slot at a time
// (table read, then judge) and visits at most MAX_ROUNDS*(task_count+1)
// slots. One command is in flight at a time; the next beat is accepted the
// cycle after the result is loaded, even while that result waits. While the
// receiver stalls, the result holds and the next command stops at its final
// step, which stalls the input. Reset makes slot 0 the only active slot,
// clears the task count and the slot times and runs slot 0.
// ----------------------------------------------------------------------------
module cooperative_task_picker_unit import ctp_pkg::*; #(
	parameter int MAX_TASKS  = MAX_TASKS_DEF,
	parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [3:0]  task_slot,
	input  wire logic [31:0] now_us,
	input  wire logic [15:0] wait_us,
	input  wire logic        from_isr,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [3:0]       running_slot,
	output logic [3:0]       new_slot
);
	ctp_cmd_t  cmd;
	ctp_stat_t stat;

	ctp_control u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
	);

	ctp_datapath #(.MAX_TASKS(MAX_TASKS), .MAX_ROUNDS(MAX_ROUNDS)) u_dp (
		.clk, .arst_n, .cmd, .stat, .command, .task_slot, .now_us, .wait_us,
		.from_isr, .status, .running_slot, .new_slot
	);
endmodule
`default_nettype wire
